[rtl/scbs_pkg.sv]
// Shared types, constants and helpers for the sample consensus background subtractor.
// No dependencies; every other file imports this package.
package scbs_pkg;

  // Default store geometry
  localparam int SCBS_MAX_ROWS    = 256;
  localparam int SCBS_MAX_COLS    = 256;
  localparam int SCBS_MAX_SAMPLES = 32;

  // Foreground run limits
  localparam logic [7:0] GHOST_LIMIT = 8'd50;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_SAMPLES = 3'd0;
  localparam logic [2:0] CFG_MIN_MATCHES = 3'd1;
  localparam logic [2:0] CFG_RADIUS      = 3'd2;
  localparam logic [2:0] CFG_FRAME_ROWS  = 3'd3;
  localparam logic [2:0] CFG_FRAME_COLS  = 3'd4;

  // Commands
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_LOAD     = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic [7:0] pixel_value;
    logic [7:0] self_gate;
    logic [4:0] self_slot;
    logic [7:0] nbr_gate;
    logic [3:0] nbr_dy_pick;
    logic [3:0] nbr_dx_pick;
    logic [4:0] nbr_slot;
  } in_item_t;

  typedef struct packed {
    logic       is_foreground;
    logic [7:0] fg_run_count;
  } out_item_t;

  // Neighbour offset table {-1,0,1,-1,1,-1,0,1,0}; picks above 8 act as 8
  function automatic logic signed [1:0] nbr_offset(input logic [3:0] pick);
    logic signed [1:0] off;
    case (pick)
      4'd0: off = -2'sd1;
      4'd1: off = 2'sd0;
      4'd2: off = 2'sd1;
      4'd3: off = -2'sd1;
      4'd4: off = 2'sd1;
      4'd5: off = -2'sd1;
      4'd6: off = 2'sd0;
      4'd7: off = 2'sd1;
      default: off = 2'sd0;
    endcase
    return off;
  endfunction

endpackage

[rtl/scbs_if.sv]
// Valid/ready stream interfaces for the input and result channels.
// Depends on scbs_pkg for the payload types.
interface scbs_in_if import scbs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scbs_out_if import scbs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/scbs_nbr.sv]
// Neighbour cell address: offset lookup, clamp into the frame, cell index.
// Depends on scbs_pkg (offset table).
module scbs_nbr import scbs_pkg::*; #(
  parameter int MAX_ROWS = SCBS_MAX_ROWS,
  parameter int MAX_COLS = SCBS_MAX_COLS,
  parameter int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  parameter int CELL_W   = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic [RW-1:0]     row,
  input  logic [CW-1:0]     col,
  input  logic [3:0]        dy_pick,
  input  logic [3:0]        dx_pick,
  input  logic [8:0]        frame_rows,
  input  logic [8:0]        frame_cols,
  output logic [CELL_W-1:0] nbr_idx
);

  logic [13:0]        rows_eff, cols_eff;
  logic signed [14:0] pr, pc;
  logic [RW-1:0]      nr;
  logic [CW-1:0]      nc;

  // Effective frame size, clamped to [1, MAX]
  always_comb begin
    if (frame_rows == 9'd0) rows_eff = 14'd1;
    else if (14'(frame_rows) > 14'(MAX_ROWS)) rows_eff = 14'(MAX_ROWS);
    else rows_eff = 14'(frame_rows);
    if (frame_cols == 9'd0) cols_eff = 14'd1;
    else if (14'(frame_cols) > 14'(MAX_COLS)) cols_eff = 14'(MAX_COLS);
    else cols_eff = 14'(frame_cols);
  end

  // Shifted position clamped into the frame
  always_comb begin
    pr = $signed({1'b0, 14'(row)}) + 15'(nbr_offset(dy_pick));
    pc = $signed({1'b0, 14'(col)}) + 15'(nbr_offset(dx_pick));
    if (pr < 0) nr = '0;
    else if (pr > $signed({1'b0, rows_eff - 14'd1})) nr = RW'(rows_eff - 14'd1);
    else nr = RW'(pr);
    if (pc < 0) nc = '0;
    else if (pc > $signed({1'b0, cols_eff - 14'd1})) nc = CW'(cols_eff - 14'd1);
    else nc = CW'(pc);
  end

  assign nbr_idx = CELL_W'(CELL_W'(nr) * CELL_W'(MAX_COLS)) + CELL_W'(nc);

endmodule

[rtl/sample_consensus_background_subtractor_top.sv]
// Sample consensus background subtractor: per-pixel sample store, foreground
// run counters, classify and update. Depends on scbs_pkg, scbs_if, scbs_nbr.
//
// One item at a time: a classify with neighbour update goes from transfer in
// to result registered through sample word and counter read, lane compare
// with per-group counts, decision plus own-sample and counter write, neighbour
// sample write and result; a load or a pixel without neighbour update skips
// the neighbour sample write. The single write port of the sample memory
// sets this. The result sits in an output register and the next item is taken
// the cycle after that register has room. After reset a clearing pass zeroes
// both memories, one cell per cycle, over all MAX_ROWS*MAX_COLS cells (65536
// by default); no item is taken meanwhile, configuration writes are. Each
// cell's samples are one memory word of MAX_SAMPLES bytes, written one byte
// lane at a time outside the clearing pass.
module sample_consensus_background_subtractor_top import scbs_pkg::*; #(
  parameter int MAX_ROWS    = SCBS_MAX_ROWS,
  parameter int MAX_COLS    = SCBS_MAX_COLS,
  parameter int MAX_SAMPLES = SCBS_MAX_SAMPLES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [8:0] cfg_wdata,
  scbs_in_if.sink    in_ch,
  scbs_out_if.source out_ch
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int WW     = MAX_SAMPLES * 8;
  localparam int GRP    = (MAX_SAMPLES + 7) / 8;
  localparam int SUM_W  = $clog2(MAX_SAMPLES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_NBR  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Configuration registers
  logic [5:0] num_samples_r, min_matches_r;
  logic [7:0] radius_r;
  logic [8:0] frame_rows_r, frame_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_samples_r <= 6'd20;
      min_matches_r <= 6'd2;
      radius_r      <= 8'd20;
      frame_rows_r  <= 9'd256;
      frame_cols_r  <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NUM_SAMPLES: num_samples_r <= cfg_wdata[5:0];
        CFG_MIN_MATCHES: min_matches_r <= cfg_wdata[5:0];
        CFG_RADIUS:      radius_r      <= cfg_wdata[7:0];
        CFG_FRAME_ROWS:  frame_rows_r  <= cfg_wdata;
        CFG_FRAME_COLS:  frame_cols_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective sample count, clamped to [1, MAX_SAMPLES]
  logic [6:0] ns_eff;
  always_comb begin
    if (num_samples_r == 6'd0) ns_eff = 7'd1;
    else if (7'(num_samples_r) > 7'(MAX_SAMPLES)) ns_eff = 7'(MAX_SAMPLES);
    else ns_eff = 7'(num_samples_r);
  end

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic              clr_r;
  logic [CELL_W-1:0] clr_cnt_r;
  logic              out_valid_r;
  logic              in_xfer;

  assign in_ch.ready = (state_r == S_IDLE) && !clr_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Input decode: clamped position, cell, clamped slots
  logic [12:0]       row_c, col_c;
  logic [RW-1:0]     in_row;
  logic [CW-1:0]     in_col;
  logic [CELL_W-1:0] in_cell;
  logic [LW-1:0]     in_sslot, in_nslot;

  always_comb begin
    row_c = 13'(in_ch.data.pixel_row);
    col_c = 13'(in_ch.data.pixel_col);
    if (row_c > 13'(MAX_ROWS - 1)) row_c = 13'(MAX_ROWS - 1);
    if (col_c > 13'(MAX_COLS - 1)) col_c = 13'(MAX_COLS - 1);
    in_row  = RW'(row_c);
    in_col  = CW'(col_c);
    in_cell = CELL_W'(CELL_W'(in_row) * CELL_W'(MAX_COLS)) + CELL_W'(in_col);
    if (7'(in_ch.data.self_slot) > ns_eff - 7'd1) in_sslot = LW'(ns_eff - 7'd1);
    else in_sslot = LW'(in_ch.data.self_slot);
    if (7'(in_ch.data.nbr_slot) > ns_eff - 7'd1) in_nslot = LW'(ns_eff - 7'd1);
    else in_nslot = LW'(in_ch.data.nbr_slot);
  end

  // Captured item
  logic              cmd_r;
  logic [7:0]        val_r, self_gate_r, nbr_gate_r;
  logic [3:0]        dy_pick_r, dx_pick_r;
  logic [LW-1:0]     sslot_r, nslot_r;
  logic [RW-1:0]     row_r;
  logic [CW-1:0]     col_r;
  logic [CELL_W-1:0] cell_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r       <= in_ch.data.cmd;
      val_r       <= in_ch.data.pixel_value;
      self_gate_r <= in_ch.data.self_gate;
      nbr_gate_r  <= in_ch.data.nbr_gate;
      dy_pick_r   <= in_ch.data.nbr_dy_pick;
      dx_pick_r   <= in_ch.data.nbr_dx_pick;
      sslot_r     <= in_sslot;
      nslot_r     <= in_nslot;
      row_r       <= in_row;
      col_r       <= in_col;
      cell_r      <= in_cell;
    end
  end

  // Neighbour cell
  logic [CELL_W-1:0] nbr_cell;
  scbs_nbr #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .RW(RW),
    .CW(CW),
    .CELL_W(CELL_W)
  ) u_nbr (
    .row(row_r),
    .col(col_r),
    .dy_pick(dy_pick_r),
    .dx_pick(dx_pick_r),
    .frame_rows(frame_rows_r),
    .frame_cols(frame_cols_r),
    .nbr_idx(nbr_cell)
  );

  // Write port controls
  logic              smp_we, cnt_we;
  logic [CELL_W-1:0] smp_waddr;
  logic [LW-1:0]     smp_wlane;
  logic [7:0]        cnt_wdata;

  // Sample memory: one word per cell, byte lane writes, registered read
  logic [WW-1:0] smp_mem [CELLS];
  logic [WW-1:0] smp_rd_r;

  always_ff @(posedge clk) begin
    if (clr_r) begin
      smp_mem[clr_cnt_r] <= '0;
    end else if (smp_we) begin
      smp_mem[smp_waddr][smp_wlane*8 +: 8] <= val_r;
    end
    if (in_xfer) begin
      smp_rd_r <= smp_mem[in_cell];
    end
  end

  // Foreground counter memory
  logic [7:0] cnt_mem [CELLS];
  logic [7:0] cnt_rd_r;

  always_ff @(posedge clk) begin
    if (clr_r) begin
      cnt_mem[clr_cnt_r] <= '0;
    end else if (cnt_we) begin
      cnt_mem[cell_r] <= cnt_wdata;
    end
    if (in_xfer) begin
      cnt_rd_r <= cnt_mem[in_cell];
    end
  end

  // Lane compare, counted per group of eight lanes
  logic [3:0] grp_cnt_nxt [GRP];
  logic [3:0] grp_cnt_r   [GRP];

  always_comb begin
    logic [7:0] s, d;
    s = '0;
    d = '0;
    for (int g = 0; g < GRP; g++) begin
      grp_cnt_nxt[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (g * 8 + j < MAX_SAMPLES) begin
          s = smp_rd_r[(g*8+j)*8 +: 8];
          d = (s > val_r) ? s - val_r : val_r - s;
          if ((7'(g * 8 + j) < ns_eff) && (d < radius_r))
            grp_cnt_nxt[g] = grp_cnt_nxt[g] + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      grp_cnt_r <= grp_cnt_nxt;
    end
  end

  // Decision
  logic [SUM_W-1:0] match_cnt;
  logic             is_bg;
  logic [7:0]       cnt_inc;

  always_comb begin
    match_cnt = '0;
    for (int g = 0; g < GRP; g++) match_cnt = match_cnt + SUM_W'(grp_cnt_r[g]);
    is_bg   = 7'(match_cnt) >= 7'(min_matches_r);
    cnt_inc = (cnt_rd_r < COUNT_MAX) ? cnt_rd_r + 8'd1 : cnt_rd_r;
  end

  // Sequencer and memory writes
  logic       res_fg_r;
  logic [7:0] res_cnt_r;

  always_comb begin
    state_nxt = state_r;
    smp_we    = 1'b0;
    smp_waddr = cell_r;
    smp_wlane = sslot_r;
    cnt_we    = 1'b0;
    cnt_wdata = '0;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_OUT;
        if (cmd_r == CMD_LOAD) begin
          smp_we = 1'b1;
        end else if (is_bg) begin
          cnt_we = 1'b1;
          smp_we = (self_gate_r == 8'd0);
          if (nbr_gate_r == 8'd0) state_nxt = S_NBR;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_inc;
          smp_we    = (cnt_inc > GHOST_LIMIT);
        end
      end
      S_NBR: begin
        smp_we    = 1'b1;
        smp_waddr = nbr_cell;
        smp_wlane = nslot_r;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == CELL_W'(CELLS - 1)) clr_r <= 1'b0;
      end
    end
  end

  // Result of the current item
  always_ff @(posedge clk) begin
    if (state_r == S_DEC) begin
      res_fg_r  <= (cmd_r == CMD_CLASSIFY) && !is_bg;
      res_cnt_r <= (cmd_r == CMD_CLASSIFY && !is_bg) ? cnt_inc : 8'd0;
    end
  end

  // Output register
  logic       out_fg_r;
  logic [7:0] out_cnt_r;
  logic       out_load;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fg_r  <= res_fg_r;
      out_cnt_r <= res_cnt_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.data.is_foreground = out_fg_r;
  assign out_ch.data.fg_run_count  = out_cnt_r;

endmodule
